>>> hw/rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the alphabet decode for the base64 stream decoder.
// No dependencies; every other file in hw/rtl imports this package.
package b64d_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Group queue between the front and the back (power of two, pointers wrap)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] status;
      logic       last_result;
   } rsp_type;

   // One decoded quad or one error, expanded by the back into 1..3 results
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;
      logic [1:0]  status;
      logic        last;
   } group_type;

   // Returns {valid, sextet}; sextet is zero for characters outside the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h47)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c + 8'h04)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/b64d_front.sv
`timescale 1ns / 1ps
// Front end: accepts characters, tracks quad position and padding, and
// pushes decoded quads or error groups. Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  req_type   req_item,
   output logic      req_stall,
   input  logic      q_full,
   output logic      push,
   output group_type grp
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] held_ff, held_in;
   logic        disc_ff, disc_in;
   logic [1:0]  padc_ff, padc_in;

   logic        accept;
   logic [6:0]  dec;
   logic        valid_c;
   logic [5:0]  v;
   logic        is_pad;
   logic        last;
   logic [1:0]  padc_fin;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign dec       = sextet_of(req_item.char_code);
   assign valid_c   = dec[6];
   assign is_pad    = (req_item.char_code == PAD_CHAR);
   assign last      = req_item.last_char;

   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      disc_in  = disc_ff;
      padc_in  = padc_ff;
      push     = 1'b0;
      grp      = '0;
      v        = dec[5:0];
      padc_fin = padc_ff;
      if (accept) begin
         priority if (disc_ff) begin
            // drop input until the end of the message
            if (last) begin
               disc_in = 1'b0;
               pos_in  = 2'd0;
               held_in = 18'd0;
               padc_in = 2'd0;
            end
         end else if (last && pos_ff != 2'd3) begin
            push       = 1'b1;
            grp.count  = 2'd1;
            grp.status = STATUS_BAD_LEN;
            grp.last   = 1'b1;
         end else if (pos_ff != 2'd3) begin
            if (!valid_c && !(pos_ff == 2'd2 && is_pad)) begin
               push       = 1'b1;
               grp.count  = 2'd1;
               grp.status = STATUS_BAD_CHAR;
               grp.last   = 1'b1;
            end else begin
               if (is_pad) begin
                  v       = 6'd0;
                  padc_in = 2'd1;
               end
               held_in = {held_ff[11:0], v};
               pos_in  = pos_ff + 2'd1;
            end
         end else begin
            // fourth place: close the quad
            if ((is_pad && !last) || (!is_pad && (!valid_c || padc_ff != 2'd0))) begin
               push       = 1'b1;
               grp.count  = 2'd1;
               grp.status = STATUS_BAD_CHAR;
               grp.last   = 1'b1;
            end else begin
               if (is_pad) begin
                  v        = 6'd0;
                  padc_fin = padc_ff + 2'd1;
               end
               push       = 1'b1;
               grp.triple = {held_ff, v};
               grp.count  = 2'd3 - padc_fin;
               grp.status = STATUS_OK;
               grp.last   = last;
            end
         end
         // every group ends the quad; an error not at the end starts discarding
         if (push) begin
            pos_in  = 2'd0;
            held_in = 18'd0;
            padc_in = 2'd0;
            disc_in = (grp.status != STATUS_OK) && !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         held_ff <= 18'd0;
         disc_ff <= 1'b0;
         padc_ff <= 2'd0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         disc_ff <= disc_in;
         padc_ff <= padc_in;
      end
   end

   a_push_clears_quad: assert property (@(posedge clock) disable iff (reset)
      push |=> (pos_ff == 2'd0 && padc_ff == 2'd0))
      else $error("quad state not cleared after a group");

   a_no_push_while_discarding: assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> !push)
      else $error("group pushed while discarding");

endmodule

>>> hw/rtl/b64d_queue.sv
`timescale 1ns / 1ps
// Short group queue between front and back; push and pop may share a cycle.
// Depends on b64d_pkg.
module b64d_queue import b64d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type wr_grp,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output group_type head
);

   group_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      cnt_in    = cnt_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

>>> hw/rtl/b64d_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued group into its results, one per cycle while
// rsp_stall is low, through a registered output stage. Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  group_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_item
);

   logic [1:0] k_ff, k_in;
   logic       vld_ff, vld_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       last_k;
   logic [7:0] sel_byte;

   assign load   = head_valid && (!vld_ff || !rsp_stall);
   assign last_k = (k_ff == head.count - 2'd1);
   assign pop    = load && last_k;

   always_comb begin
      unique case (k_ff)
         2'd0:    sel_byte = head.triple[23:16];
         2'd1:    sel_byte = head.triple[15:8];
         2'd2:    sel_byte = head.triple[7:0];
         default: sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      k_in   = k_ff;
      vld_in = vld_ff;
      out_in = out_ff;
      if (load) begin
         vld_in             = 1'b1;
         out_in.data_byte   = sel_byte;
         out_in.status      = head.status;
         out_in.last_result = head.last && last_k;
         k_in               = last_k ? 2'd0 : k_ff + 2'd1;
      end else if (!rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         k_ff   <= k_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = out_ff;

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      (head_valid && k_ff != 2'd0) |-> (k_ff < head.count))
      else $error("result index past the end of its group");

endmodule

>>> hw/rtl/base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Base64 stream decoder, top level. Depends on b64d_pkg, b64d_front,
// b64d_queue and b64d_back.
//
// Usage:
//   req channel: one base64 character per item (char_code), with last_char
//   set on the final character of a message. An item is taken at a clock
//   edge with req_valid high and req_stall low.
//   rsp channel: decoded bytes, one per item, most significant first, with
//   status (ok, invalid character, invalid length) and last_result on the
//   final result of each message. An error gives one result with a zero
//   byte that ends the message; input is then dropped up to last_char.
//   Throughput: one character per cycle while req_stall is low; the back
//   end emits one result per cycle while rsp_stall is low, so a full quad
//   (three bytes) drains before the next quad has arrived.
//   Path: a character that closes a group writes it into the group queue;
//   its first result is then loaded into the output register, and the rest
//   follow in order.
//   Stall: when rsp_stall is held, results wait in the output register and
//   a four-entry group queue; req_stall rises only when that queue is full.
//   Reset (synchronous, active high) clears quad state, discard mode, the
//   queue and the output valid; the block takes input on the next cycle.
module base64_stream_decoder_unit import b64d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_item,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic      push;
   group_type wr_grp;
   logic      q_full;
   logic      pop;
   logic      head_valid;
   group_type head;

   // Classify characters and assemble quads
   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .q_full    (q_full),
      .push      (push),
      .grp       (wr_grp)
   );

   // Hold groups between the two sides so each can stall on its own
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .wr_grp     (wr_grp),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Expand groups into byte results
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
